### rtl/psi_delta_run_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Psi delta run tokenizer assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PSI_DELTA_RUN_TOKENIZER_DEFINES_SVH
`define PSI_DELTA_RUN_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define PDRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psi_delta_run_tokenizer: check failed");

// antecedent implies consequent in the next cycle
`define PDRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psi_delta_run_tokenizer: check failed");

`else

`define PDRT_ASSERT_SAME(label, clk, rst, ante, cons)
`define PDRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/psidrt_pkg.sv
// ----------------------------------------------------------------------------
// psidrt_pkg
// Types and constants shared by the Psi delta run tokenizer modules.
// ----------------------------------------------------------------------------
package psidrt_pkg;

   localparam int VALUE_WIDTH = 32;   // bits of psi_value that are used
   localparam int COUNT_WIDTH = 16;   // position and run counters

   localparam int PERIOD_W    = 16;
   localparam int SYM_W       = 17;
   localparam int RAW_LEN_W   = 6;
   localparam int FIELD_W     = 32;
   localparam int RUN_START_W = SYM_W + 2;
   localparam int CMP_W       = (VALUE_WIDTH + 1 > RUN_START_W) ? VALUE_WIDTH + 1 : RUN_START_W;
   localparam int BITS_W      = $clog2(VALUE_WIDTH + 1);

   localparam int NEG_OFFSET  = 64;
   localparam int BIG_OFFSET  = 32;

   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = SYM_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_COUNT  = 1'd1;

   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd32;
   localparam logic [SYM_W-1:0]    SYMBOL_COUNT_RST  = 17'd256;

   typedef struct packed {
      logic [31:0] psi_value;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic                 kind;
      logic [SYM_W-1:0]     symbol;
      logic [RAW_LEN_W-1:0] raw_length;
      logic [FIELD_W-1:0]   raw_bits;
      logic [FIELD_W-1:0]   sample_value;
      logic                 last_result;
   } rsp_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] sample_period;
      logic [SYM_W-1:0]    symbol_count;
   } cfg_type;

   // results produced by one item, in delivery order
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

### rtl/psidrt_core.sv
// ----------------------------------------------------------------------------
// psidrt_core
// Input register, tokenizer state and per-item symbol logic.
// ----------------------------------------------------------------------------
module psidrt_core
   import psidrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  cfg_type cfg,
   input  logic    room,
   output push_type push
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   function automatic logic [BITS_W-1:0] bit_count(input logic [VALUE_WIDTH-1:0] x);
      logic [BITS_W-1:0] n;
      n = '0;
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         if (x[i]) begin
            n = BITS_W'(i + 1);
         end
      end
      return n;
   endfunction

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_data_ff;
   logic [VALUE_WIDTH-1:0]   prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0]   pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0]   run_ff, run_in;

   logic                     fire, sample, last;
   logic [VALUE_WIDTH-1:0]   value;
   logic signed [VALUE_WIDTH:0] diff, neg_diff;
   logic signed [RUN_START_W-1:0] run_start;
   logic signed [CMP_W-1:0]  diff_c, run_start_c;
   logic                     diff_one, diff_small;
   logic [VALUE_WIDTH-1:0]   mag;
   logic [BITS_W-1:0]        nbits;
   logic [COUNT_WIDTH-1:0]   run_inc, run_flush, pos_inc;
   logic                     do_flush, do_main, pos_wrap;
   rsp_type                  flush_rsp, main_rsp;

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   assign value = in_data_ff.psi_value[VALUE_WIDTH-1:0];
   assign last  = in_data_ff.is_last;
   assign sample = (pos_ff == '0);

   // signed difference and the direct-code window
   assign diff      = $signed({1'b0, value}) - $signed({1'b0, prev_ff});
   assign neg_diff  = -diff;
   assign run_start = $signed({2'b00, cfg.symbol_count})
                      - $signed(RUN_START_W'(NEG_OFFSET))
                      - $signed({{(RUN_START_W-PERIOD_W){1'b0}}, cfg.sample_period});
   assign diff_c      = CMP_W'(diff);
   assign run_start_c = CMP_W'(run_start);
   assign diff_one    = (diff == (VALUE_WIDTH+1)'(1));
   assign diff_small  = !diff_c[CMP_W-1] && (diff_c > CMP_W'(1)) && (diff_c < run_start_c);

   assign mag   = diff[VALUE_WIDTH] ? neg_diff[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
   assign nbits = bit_count(mag);

   assign run_inc   = run_ff + COUNT_WIDTH'(1);
   assign run_flush = (!sample && diff_one) ? run_inc : run_ff;

   always_comb begin
      if (sample || !diff_one) begin
         do_flush = (run_ff != '0);
      end else begin
         // run_inc is never zero here: a full run or the sequence end flushes it
         do_flush = (run_inc == CNT_MAX) || last;
      end
      do_main = sample || !diff_one;
   end

   always_comb begin
      flush_rsp              = '0;
      flush_rsp.symbol       = cfg.symbol_count - SYM_W'(NEG_OFFSET)
                               - SYM_W'(cfg.sample_period) + SYM_W'(run_flush);
      flush_rsp.last_result  = !do_main;

      main_rsp               = '0;
      main_rsp.last_result   = 1'b1;
      if (sample) begin
         main_rsp.kind         = 1'b1;
         main_rsp.sample_value = FIELD_W'(value);
      end else if (diff_small) begin
         main_rsp.symbol       = SYM_W'(diff);
      end else if (diff[VALUE_WIDTH]) begin
         main_rsp.symbol       = cfg.symbol_count - SYM_W'(NEG_OFFSET)
                                 + SYM_W'(nbits) - SYM_W'(1);
         main_rsp.raw_length   = RAW_LEN_W'(nbits);
         main_rsp.raw_bits     = FIELD_W'(mag);
      end else begin
         main_rsp.symbol       = cfg.symbol_count - SYM_W'(BIG_OFFSET)
                                 + SYM_W'(nbits) - SYM_W'(1);
         main_rsp.raw_length   = RAW_LEN_W'(nbits);
         main_rsp.raw_bits     = FIELD_W'(mag);
      end
   end

   always_comb begin
      push.num    = fire ? (2'(do_flush) + 2'(do_main)) : 2'd0;
      push.first  = do_flush ? flush_rsp : main_rsp;
      push.second = main_rsp;
   end

   // next state
   assign pos_inc  = pos_ff + COUNT_WIDTH'(1);
   assign pos_wrap = (pos_inc >= cfg.sample_period) || (pos_inc == CNT_MAX);

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      prev_in     = prev_ff;
      pos_in      = pos_ff;
      run_in      = run_ff;
      if (fire) begin
         prev_in = last ? '0 : value;
         pos_in  = (last || pos_wrap) ? '0 : pos_inc;
         if (sample || !diff_one || last || run_inc == CNT_MAX) begin
            run_in = '0;
         end else begin
            run_in = run_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         prev_ff     <= '0;
         pos_ff      <= '0;
         run_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         prev_ff     <= prev_in;
         pos_ff      <= pos_in;
         run_ff      <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

endmodule

### rtl/psidrt_fifo.sv
// ----------------------------------------------------------------------------
// psidrt_fifo
// Small result queue: takes up to two results a cycle, delivers one while rsp_ready is high.
// ----------------------------------------------------------------------------
module psidrt_fifo
   import psidrt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  wr_ptr_next;
   logic              pop;

   assign room      = (fill_ff <= FILL_W'(FIFO_DEPTH - 2));
   assign rsp_valid = (fill_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      fill_in   = fill_ff + FILL_W'(push.num) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

### rtl/psi_delta_run_tokenizer.sv
// Path: an accepted transaction waits in the core's input register until the result queue has
//    room for a pair, then its results are written into the queue, which presents them on rsp.
// Throughput: one input transaction per cycle while the queue has room; the result port moves
//    one result per cycle while rsp_ready is high, so a run flush plus its own symbol is a burst of two.
// The four-entry result queue absorbs those bursts; the input stalls only when it holds 3+.
// Reset (synchronous, active high): counters, previous value and run cleared, queue empty,
//    sample_period back to 32 and symbol_count back to 256.
// ----------------------------------------------------------------------------
// psi_delta_run_tokenizer
// Turns a stream of Psi values into sample records and Huffman symbols.
// ----------------------------------------------------------------------------
`include "psi_delta_run_tokenizer_defines.svh"

module psi_delta_run_tokenizer
   import psidrt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input transactions
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   // result transactions
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   // configuration writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers; the user must write them only while idle (not enforced by the block)
   logic [PERIOD_W-1:0] sample_period_ff, sample_period_in;
   logic [SYM_W-1:0]    symbol_count_ff, symbol_count_in;
   cfg_type             cfg;
   push_type            push;
   logic                room;
   logic                pair_ok;

   always_comb begin
      sample_period_in = sample_period_ff;
      symbol_count_in  = symbol_count_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: begin
               sample_period_in = csr_wdata[PERIOD_W-1:0];
            end
            CSR_SYMBOL_COUNT: begin
               symbol_count_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= SAMPLE_PERIOD_RST;
         symbol_count_ff  <= SYMBOL_COUNT_RST;
      end else begin
         sample_period_ff <= sample_period_in;
         symbol_count_ff  <= symbol_count_in;
      end
   end

   assign cfg.sample_period = sample_period_ff;
   assign cfg.symbol_count  = symbol_count_ff;

   // input register, state and symbol logic; pushes 0..2 results per item
   psidrt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .room      (room),
      .push      (push)
   );

   // result queue, decouples bursts of two from the output of one per cycle while rsp_ready is high
   psidrt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shape of a pair: run flush first, closing result second
   assign pair_ok = (push.first.kind == 1'b0) && !push.first.last_result
                    && push.second.last_result;

   // the core never pushes into a queue without space for a pair
   `PDRT_ASSERT_SAME(a_push_room, clock, reset, push.num != 2'd0, room)
   // a pair is always a run flush followed by the closing result
   `PDRT_ASSERT_SAME(a_pair_order, clock, reset, push.num == 2'd2, pair_ok)
   // a lone result closes its item
   `PDRT_ASSERT_SAME(a_single_last, clock, reset, push.num == 2'd1, push.first.last_result)
   // the queue shows a result the cycle after any push
   `PDRT_ASSERT_NEXT(a_push_visible, clock, reset, push.num != 2'd0, rsp_valid)

endmodule
